[rtl/skslu_pkg.sv]
`timescale 1ns / 1ps

package skslu_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  localparam int OP_W   = 3;
  localparam int TAG_W  = 16;
  localparam int TIME_W = 32;
  localparam int POS_W  = 32;
  localparam int ST_W   = 2;
  localparam int HELD_W = 6;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOTAG    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_FALLBACK = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic [TIME_W-1:0]        stamp;
    logic signed [POS_W-1:0]  pos;
  } entry_t;

  typedef struct packed {
    logic   step;
    logic   keep_head;
    logic   insert;
    entry_t head;
    entry_t fresh;
  } cell_ctl_t;

endpackage

[rtl/sorted_keyframe_step_lookup_top.sv]
`timescale 1ns / 1ps
// Clear, a refused add and a spare code go straight from idle to reply, and a placed add
// passes through insert first; lookup, remove and an unmatched update scan every entry
// held, as the chain rotates once, before reply, and a matched update then also inserts.
// One item is in work at a time; the next input beat is taken once the result is
// raised, even while that result waits.
// Synchronous active-low reset empties the table and drops any pending result.
module sorted_keyframe_step_lookup_top #(
  parameter int TABLE_DEPTH = skslu_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [skslu_pkg::OP_W-1:0]           in_operation,
  input  logic [skslu_pkg::TAG_W-1:0]          in_key_tag,
  input  logic [skslu_pkg::TIME_W-1:0]         in_key_time,
  input  logic signed [skslu_pkg::POS_W-1:0]   in_key_position,
  input  logic signed [skslu_pkg::POS_W-1:0]   in_fallback_position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [skslu_pkg::POS_W-1:0]   out_target_position,
  output logic [skslu_pkg::ST_W-1:0]           out_status,
  output logic [skslu_pkg::HELD_W-1:0]         out_entries_held
);

  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int HeldW = skslu_pkg::HELD_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_INSERT = 4'b0100,
    S_REPLY  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] rem_r, rem_nxt;
  logic found_r, found_nxt;
  logic hit_r, hit_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [skslu_pkg::OP_W-1:0]          op_r, op_nxt;
  logic [skslu_pkg::TAG_W-1:0]         tag_r, tag_nxt;
  logic [skslu_pkg::TIME_W-1:0]        time_r, time_nxt;
  logic signed [skslu_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic signed [skslu_pkg::POS_W-1:0]  fallback_r, fallback_nxt;
  logic signed [skslu_pkg::POS_W-1:0]  lk_pos_r, lk_pos_nxt;
  logic signed [skslu_pkg::POS_W-1:0]  target_r, target_nxt;
  logic [skslu_pkg::ST_W-1:0]          status_r, status_nxt;
  logic signed [skslu_pkg::POS_W-1:0]  out_target_r, out_target_nxt;
  logic [skslu_pkg::ST_W-1:0]          out_status_r, out_status_nxt;
  logic [HeldW-1:0]                    out_held_r, out_held_nxt;

  skslu_pkg::cell_ctl_t ctl;
  skslu_pkg::entry_t    cell_q [TABLE_DEPTH];
  logic                 cell_gt [TABLE_DEPTH];
  skslu_pkg::entry_t    head;
  logic                 full;
  logic                 match;
  logic                 drop;

  assign head     = cell_q[0];
  assign full     = count_r == CntW'(TABLE_DEPTH);
  assign match    = head.tag == tag_r;
  assign drop     = match && ((op_r == skslu_pkg::OP_REMOVE) ||
                              ((op_r == skslu_pkg::OP_UPDATE) && !found_r));
  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    op_nxt         = op_r;
    tag_nxt        = tag_r;
    time_nxt       = time_r;
    pos_nxt        = pos_r;
    fallback_nxt   = fallback_r;
    lk_pos_nxt     = lk_pos_r;
    target_nxt     = target_r;
    status_nxt     = status_r;
    out_target_nxt = out_target_r;
    out_status_nxt = out_status_r;
    out_held_nxt   = out_held_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    ctl.step       = 1'b0;
    ctl.keep_head  = 1'b1;
    ctl.insert     = 1'b0;
    ctl.head       = head;
    ctl.fresh.tag   = tag_r;
    ctl.fresh.stamp = time_r;
    ctl.fresh.pos   = pos_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_operation;
          tag_nxt      = in_key_tag;
          time_nxt     = in_key_time;
          pos_nxt      = in_key_position;
          fallback_nxt = in_fallback_position;
          found_nxt    = 1'b0;
          hit_nxt      = 1'b0;
          rem_nxt      = count_r;
          target_nxt   = '0;
          status_nxt   = skslu_pkg::ST_DONE;
          case (in_operation)
            skslu_pkg::OP_ADD: begin
              if (full) begin
                status_nxt = skslu_pkg::ST_FULL;
                state_nxt  = S_REPLY;
              end else begin
                state_nxt = S_INSERT;
              end
            end
            skslu_pkg::OP_UPDATE,
            skslu_pkg::OP_REMOVE,
            skslu_pkg::OP_LOOKUP: begin
              state_nxt = S_SCAN;
            end
            skslu_pkg::OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_REPLY;
            end
            default: begin
              state_nxt = S_REPLY;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rem_r != '0) begin
          ctl.step      = 1'b1;
          ctl.keep_head = !drop;
          rem_nxt       = rem_r - CntW'(1);
          if (drop) begin
            found_nxt = 1'b1;
            count_nxt = count_r - CntW'(1);
          end
          if ((op_r == skslu_pkg::OP_LOOKUP) && (head.stamp <= time_r)) begin
            hit_nxt    = 1'b1;
            lk_pos_nxt = head.pos;
          end
        end else begin
          state_nxt = S_REPLY;
          case (op_r)
            skslu_pkg::OP_UPDATE: begin
              if (found_r) begin
                state_nxt = S_INSERT;
              end else begin
                status_nxt = skslu_pkg::ST_NOTAG;
              end
            end
            skslu_pkg::OP_REMOVE: begin
              status_nxt = found_r ? skslu_pkg::ST_DONE : skslu_pkg::ST_NOTAG;
            end
            default: begin
              if (hit_r) begin
                target_nxt = lk_pos_r;
              end else begin
                target_nxt = fallback_r;
                status_nxt = skslu_pkg::ST_FALLBACK;
              end
            end
          endcase
        end
      end
      S_INSERT: begin
        ctl.insert = 1'b1;
        count_nxt  = count_r + CntW'(1);
        state_nxt  = S_REPLY;
      end
      S_REPLY: begin
        if (!out_valid_r || out_ready) begin
          out_target_nxt = target_r;
          out_status_nxt = status_r;
          out_held_nxt   = HeldW'(count_r);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      skslu_pkg::entry_t left_entry;
      skslu_pkg::entry_t right_entry;
      logic              left_gt;

      if (gi == 0) begin : g_first
        assign left_entry = cell_q[0];
        assign left_gt    = 1'b0;
      end else begin : g_mid
        assign left_entry = cell_q[gi-1];
        assign left_gt    = cell_gt[gi-1];
      end

      if (gi == TABLE_DEPTH - 1) begin : g_end
        assign right_entry = cell_q[gi];
      end else begin : g_inner
        assign right_entry = cell_q[gi+1];
      end

      skslu_cell #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX         (gi)
      ) u_cell (
        .clk         (clk),
        .count       (count_r),
        .ctl         (ctl),
        .left_entry  (left_entry),
        .left_gt     (left_gt),
        .right_entry (right_entry),
        .entry_q     (cell_q[gi]),
        .gt_o        (cell_gt[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      found_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      found_r     <= found_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    tag_r        <= tag_nxt;
    time_r       <= time_nxt;
    pos_r        <= pos_nxt;
    fallback_r   <= fallback_nxt;
    lk_pos_r     <= lk_pos_nxt;
    target_r     <= target_nxt;
    status_r     <= status_nxt;
    out_target_r <= out_target_nxt;
    out_status_r <= out_status_nxt;
    out_held_r   <= out_held_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_target_position = out_target_r;
  assign out_status          = out_status_r;
  assign out_entries_held    = out_held_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_scan_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rem_r <= count_r))
    else $error("scan has more entries left than the table holds");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INSERT) |-> (count_r < CntW'(TABLE_DEPTH)))
    else $error("insert into a full table");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted beat left no work in progress");
`endif

endmodule

[rtl/skslu_cell.sv]
`timescale 1ns / 1ps

module skslu_cell #(
  parameter int TABLE_DEPTH = skslu_pkg::TABLE_DEPTH_DEF,
  parameter int IDX         = 0,
  localparam int CntW       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic [CntW-1:0]      count,
  input  skslu_pkg::cell_ctl_t ctl,
  input  skslu_pkg::entry_t    left_entry,
  input  logic                 left_gt,
  input  skslu_pkg::entry_t    right_entry,
  output skslu_pkg::entry_t    entry_q,
  output logic                 gt_o
);

  skslu_pkg::entry_t entry_r;
  skslu_pkg::entry_t entry_nxt;

  logic occupied;
  logic is_free;
  logic is_last;
  logic from_right;

  assign occupied   = CntW'(IDX) < count;
  assign is_free    = CntW'(IDX) == count;
  assign is_last    = CntW'(IDX + 1) == count;
  assign from_right = CntW'(IDX + 1) < count;
  assign gt_o       = occupied && (entry_r.stamp > ctl.fresh.stamp);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (gt_o || is_free) begin
        entry_nxt = ctl.fresh;
      end
    end else if (ctl.step) begin
      if (from_right) begin
        entry_nxt = right_entry;
      end else if (ctl.keep_head && is_last) begin
        entry_nxt = ctl.head;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule
